>>> design/npc_pkg.sv
// Types, codes and helpers shared by the nearest palette colour unit.
package npc_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    localparam int COUNT_W = 9;
    localparam int DIST_W  = 18;

    typedef struct packed {
        logic       operation;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_entry;
    } npc_cmd_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] nearest_index;
        logic [7:0] nearest_red;
        logic [7:0] nearest_green;
        logic [7:0] nearest_blue;
        logic [3:0] index_bits;
    } npc_result_t;

    typedef struct packed {
        logic               is_query;
        logic               emit;
        logic [7:0]         slot;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COUNT_W-1:0] count;
        logic [3:0]         index_bits;
        logic [DIST_W-1:0]  best_dist;
        logic [7:0]         best_index;
        logic [7:0]         best_red;
        logic [7:0]         best_green;
        logic [7:0]         best_blue;
    } npc_item_t;

    // ceil(log2(slot + 1)) is the bit length of slot
    function automatic logic [3:0] npc_index_bits(input logic [7:0] slot);
        logic [3:0] bits;
        bits = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (slot[i]) begin
                bits = 4'(i + 1);
            end
        end
        return bits;
    endfunction

endpackage

>>> design/npc_cell.sv
// One palette cell: holds an entry, takes loads for its slot, updates the running best.
module npc_cell
    import npc_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  npc_item_t up_item,
    output logic      dn_valid,
    output npc_item_t dn_item
);

    localparam logic [7:0]         CELL_ID    = 8'(CELL_INDEX);
    localparam logic [COUNT_W-1:0] CELL_LIMIT = COUNT_W'(CELL_INDEX);

    logic [7:0]        entry_red_reg;
    logic [7:0]        entry_green_reg;
    logic [7:0]        entry_blue_reg;
    logic              valid_reg;
    npc_item_t         item_reg;
    npc_item_t         item_next;
    logic [7:0]        diff_r;
    logic [7:0]        diff_g;
    logic [7:0]        diff_b;
    logic [15:0]       sq_r;
    logic [15:0]       sq_g;
    logic [15:0]       sq_b;
    logic [DIST_W-1:0] dist_sum;
    logic              active;
    logic              write_here;

    always_comb
    begin
        diff_r = (up_item.red > entry_red_reg) ? up_item.red - entry_red_reg
                                               : entry_red_reg - up_item.red;
        diff_g = (up_item.green > entry_green_reg) ? up_item.green - entry_green_reg
                                                   : entry_green_reg - up_item.green;
        diff_b = (up_item.blue > entry_blue_reg) ? up_item.blue - entry_blue_reg
                                                 : entry_blue_reg - up_item.blue;
        sq_r = 16'(diff_r) * 16'(diff_r);
        sq_g = 16'(diff_g) * 16'(diff_g);
        sq_b = 16'(diff_b) * 16'(diff_b);
        dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

        active     = up_item.is_query && (CELL_LIMIT < up_item.count);
        write_here = up_valid && !up_item.is_query && (up_item.slot == CELL_ID);

        item_next = up_item;
        // strict compare keeps the lowest slot on ties
        if (active && (dist_sum < up_item.best_dist))
        begin
            item_next.best_dist  = dist_sum;
            item_next.best_index = CELL_ID;
            item_next.best_red   = entry_red_reg;
            item_next.best_green = entry_green_reg;
            item_next.best_blue  = entry_blue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (write_here)
        begin
            entry_red_reg   <= up_item.red;
            entry_green_reg <= up_item.green;
            entry_blue_reg  <= up_item.blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_valid;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

>>> design/nearest_palette_colour_unit.sv
// Top level of the nearest palette colour unit: issue stage, cell chain, result register.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// A load item (operation = load) writes one RGB entry to its slot; the load
// item with last_entry set fixes the count at entry_index + 1 and produces a
// report carrying index_bits. A query item produces the palette entry at
// least squared RGB distance (lowest slot on ties) and its slot, once a load
// has completed. Loads with a slot at or above MAX_ENTRIES, non-final loads
// and queries before a completed load produce nothing.
// A result shows on done/result once its item has passed the issue register,
// one cell per palette entry and the output register. Throughput: one item
// per cycle; the cell chain sets the depth. Items pass through the chain in
// order, so a query sees every load taken before it and none taken after it.
// Reset: count and ready state clear, the chain empties, busy is high for
// the reset cycle and then stays low. Palette entries are not cleared.
// done is a one-cycle strobe; the receiver cannot stall the unit.
module nearest_palette_colour_unit
    import npc_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  npc_cmd_t    command,
    output logic        done,
    output npc_result_t result
);

    localparam int LATENCY = MAX_ENTRIES + 2;

    logic               busy_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               ready_reg;
    logic               ready_next;
    logic [3:0]         ibits_reg;
    logic [3:0]         ibits_next;
    logic               head_valid_reg;
    logic               head_valid_next;
    npc_item_t          head_item_reg;
    npc_item_t          head_item_next;
    logic               done_reg;
    npc_result_t        result_reg;
    npc_result_t        result_next;
    logic               accept;
    logic               in_range;

    logic      chain_valid [MAX_ENTRIES+1];
    npc_item_t chain_item  [MAX_ENTRIES+1];

    assign accept   = start && !busy_reg;
    assign in_range = COUNT_W'(command.entry_index) < COUNT_W'(MAX_ENTRIES);

    always_comb
    begin
        count_next      = count_reg;
        ready_next      = ready_reg;
        ibits_next      = ibits_reg;
        head_valid_next = 1'b0;

        head_item_next            = '0;
        head_item_next.slot       = command.entry_index;
        head_item_next.red        = command.red;
        head_item_next.green      = command.green;
        head_item_next.blue       = command.blue;
        head_item_next.best_dist  = '1;

        if (accept)
        begin
            if (command.operation == OP_LOAD)
            begin
                if (in_range)
                begin
                    head_valid_next = 1'b1;
                    if (command.last_entry)
                    begin
                        count_next = COUNT_W'(command.entry_index) + COUNT_W'(1);
                        ready_next = 1'b1;
                        ibits_next = npc_index_bits(command.entry_index);
                    end
                    else
                    begin
                        ready_next = 1'b0;
                    end
                end
                head_item_next.is_query = 1'b0;
                head_item_next.emit     = command.last_entry;
            end
            else
            begin
                head_valid_next         = ready_reg;
                head_item_next.is_query = 1'b1;
                head_item_next.emit     = 1'b1;
            end
        end
        head_item_next.count      = count_next;
        head_item_next.index_bits = ibits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            count_reg      <= '0;
            ready_reg      <= 1'b0;
            ibits_reg      <= 4'd0;
            head_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= 1'b0;
            count_reg      <= count_next;
            ready_reg      <= ready_next;
            ibits_reg      <= ibits_next;
            head_valid_reg <= head_valid_next;
            done_reg       <= chain_valid[MAX_ENTRIES] && chain_item[MAX_ENTRIES].emit;
        end
    end

    always_ff @(posedge clk)
    begin
        head_item_reg <= head_item_next;
        result_reg    <= result_next;
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_item[0]  = head_item_reg;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        npc_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_item  (chain_item[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_item  (chain_item[g+1])
        );
    end

    always_comb
    begin
        result_next            = '0;
        result_next.index_bits = chain_item[MAX_ENTRIES].index_bits;
        if (chain_item[MAX_ENTRIES].is_query)
        begin
            result_next.kind          = KIND_ANSWER;
            result_next.nearest_index = chain_item[MAX_ENTRIES].best_index;
            result_next.nearest_red   = chain_item[MAX_ENTRIES].best_red;
            result_next.nearest_green = chain_item[MAX_ENTRIES].best_green;
            result_next.nearest_blue  = chain_item[MAX_ENTRIES].best_blue;
        end
        else
        begin
            result_next.kind = KIND_REPORT;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // every result traces back to an item that the unit took earlier
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == KIND_REPORT) |->
            (result.nearest_index == 8'd0 && result.nearest_red == 8'd0 &&
             result.nearest_green == 8'd0 && result.nearest_blue == 8'd0))
        else $error("load report carries colour data");

    a_query_needs_palette: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && head_item_reg.is_query) |-> (head_item_reg.count != '0))
        else $error("query issued against an empty palette");

    a_query_found_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[MAX_ENTRIES] && chain_item[MAX_ENTRIES].is_query) |->
            (chain_item[MAX_ENTRIES].best_dist != '1))
        else $error("query left the chain without a match");

endmodule
